>>> src/assert_macros.svh
// Assertion macros used by the tokenizer RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define ASSERT_IMPLIES(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("tokenizer assertion failed");

// Next-cycle implication, disabled during reset.
`define ASSERT_NEXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("tokenizer assertion failed");

`endif

>>> src/bst_pkg.sv
// Package: token kinds, character codes and result types of the tokenizer.
`timescale 1ns / 1ps
`default_nettype none
package bst_pkg;

   localparam int ROW_BITS   = 16;
   localparam int LEN_BITS   = 16;
   localparam int OFF_BITS   = 24;
   localparam int VALUE_BITS = 31;

   localparam logic [ROW_BITS-1:0]   POS_MAX = 16'hFFFF;
   localparam logic [VALUE_BITS-1:0] NUM_MAX = 31'h7FFF_FFFF;

   localparam logic [7:0] CHAR_TAB     = 8'h09;
   localparam logic [7:0] CHAR_CR      = 8'h0D;
   localparam logic [7:0] CHAR_NEWLINE = 8'h0A;
   localparam logic [7:0] CHAR_SPACE   = 8'h20;
   localparam logic [7:0] CHAR_QUOTE   = 8'h22;
   localparam logic [7:0] CHAR_HASH    = 8'h23;
   localparam logic [7:0] CHAR_LPAREN  = 8'h28;
   localparam logic [7:0] CHAR_RPAREN  = 8'h29;
   localparam logic [7:0] CHAR_ZERO    = 8'h30;
   localparam logic [7:0] CHAR_NINE    = 8'h39;
   localparam logic [7:0] CHAR_SEMI    = 8'h3B;
   localparam logic [7:0] CHAR_UPPER_A = 8'h41;
   localparam logic [7:0] CHAR_UPPER_Z = 8'h5A;
   localparam logic [7:0] CHAR_LOWER_A = 8'h61;
   localparam logic [7:0] CHAR_LOWER_Z = 8'h7A;
   localparam logic [7:0] CHAR_LBRACE  = 8'h7B;
   localparam logic [7:0] CHAR_RBRACE  = 8'h7D;

   typedef enum logic [3:0] {
      KIND_IDENT  = 4'd0,
      KIND_LPAREN = 4'd1,
      KIND_RPAREN = 4'd2,
      KIND_LBRACE = 4'd3,
      KIND_RBRACE = 4'd4,
      KIND_SEMI   = 4'd5,
      KIND_NUMBER = 4'd6,
      KIND_STRING = 4'd7,
      KIND_ERROR  = 4'd8
   } bst_kind_type;

   typedef struct packed {
      bst_kind_type          kind;
      logic [ROW_BITS-1:0]   row;
      logic [ROW_BITS-1:0]   col;
      logic [OFF_BITS-1:0]   offset;
      logic [LEN_BITS-1:0]   length;
      logic [VALUE_BITS-1:0] value;
      logic                  last;
   } bst_result_type;

   // Results produced by one request: count is 0, 1 or 2, r0 goes out first.
   typedef struct packed {
      logic [1:0]     count;
      bst_result_type r0;
      bst_result_type r1;
   } bst_push_type;

endpackage
`default_nettype wire

>>> src/byte_stream_tokenizer_unit.sv
// Top level of the byte stream tokenizer.
`timescale 1ns / 1ps
`default_nettype none
// Byte stream tokenizer. Source text enters one byte per request; tokens
// (identifiers, ( ) { } ;, decimal numbers, double-quoted strings, error
// tokens for unknown bytes) leave one per response, each with its kind,
// start row/column/offset, text length and, for numbers, a saturating value.
// A request may cause zero, one or two responses; rsp_last_of_run marks the
// last response caused by a request. end_marker flushes a pending token and
// returns all position counters to zero.
// Rate: one request per clock while req_stall is low. The scanner state updates in the cycle a
// request is taken, and its results land in a three-entry result queue that
// drives the rsp_ ports from registers. req_stall rises when the queue, after
// this cycle's pop, has fewer than two free slots. With rsp_stall low the
// block takes one request per clock, except that a request yielding two
// tokens leaves one result queued; a second two-token request that comes
// before any token-free request then fills the queue, and the request after
// it is stalled until a pop leaves room for two results.
// OFFSET_BITS sets the width of the internal byte offset counter; the
// offset wraps at 2^OFFSET_BITS and its low 24 bits are reported.
module byte_stream_tokenizer_unit #(
   parameter int OFFSET_BITS = 24
) (
   input  wire logic         clock,
   input  wire logic         reset,

   input  wire logic         req_valid,
   output logic              req_stall,
   input  wire logic [7:0]   req_char_byte,
   input  wire logic         req_end_marker,

   output logic              rsp_valid,
   input  wire logic         rsp_stall,
   output logic [3:0]        rsp_token_kind,
   output logic [15:0]       rsp_start_row,
   output logic [15:0]       rsp_start_col,
   output logic [23:0]       rsp_start_offset,
   output logic [15:0]       rsp_text_length,
   output logic [30:0]       rsp_number_value,
   output logic              rsp_last_of_run
);
   import bst_pkg::*;

   logic            take;      // request accepted this cycle
   bst_push_type    push;      // results of the accepted request
   bst_result_type  head;      // oldest queued result

   assign take = req_valid && !req_stall;

   // scanner: mode, position counters and the pending token
   bst_scan #(
      .OFFSET_BITS (OFFSET_BITS)
   ) u_scan (
      .clock      (clock),
      .reset      (reset),
      .take       (take),
      .char_byte  (req_char_byte),
      .end_marker (req_end_marker),
      .push       (push)
   );

   // result queue decouples the response side from the scanner
   bst_outq u_outq (
      .clock     (clock),
      .reset     (reset),
      .take      (take),
      .push      (push),
      .rsp_stall (rsp_stall),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .head      (head)
   );

   assign rsp_token_kind   = head.kind;
   assign rsp_start_row    = head.row;
   assign rsp_start_col    = head.col;
   assign rsp_start_offset = head.offset;
   assign rsp_text_length  = head.length;
   assign rsp_number_value = head.value;
   assign rsp_last_of_run  = head.last;

endmodule
`default_nettype wire

>>> src/bst_scan.sv
// Scanner: running position and token state, and the results of one request.
`timescale 1ns / 1ps
`default_nettype none
module bst_scan #(
   parameter int OFFSET_BITS = 24
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                take,
   input  wire logic [7:0]          char_byte,
   input  wire logic                end_marker,
   output bst_pkg::bst_push_type    push
);
   import bst_pkg::*;

   typedef enum logic [2:0] {
      MODE_IDLE,
      MODE_IDENT,
      MODE_NUMBER,
      MODE_STRING,
      MODE_COMMENT
   } mode_type;

   mode_type                mode_ff, mode_in;
   logic [ROW_BITS-1:0]     cur_row_ff, cur_row_in;
   logic [ROW_BITS-1:0]     cur_col_ff, cur_col_in;
   logic [OFFSET_BITS-1:0]  cur_off_ff, cur_off_in;
   logic [ROW_BITS-1:0]     tok_row_ff, tok_row_in;
   logic [ROW_BITS-1:0]     tok_col_ff, tok_col_in;
   logic [OFFSET_BITS-1:0]  tok_off_ff, tok_off_in;
   logic [LEN_BITS-1:0]     tok_len_ff, tok_len_in;
   logic [VALUE_BITS-1:0]   num_ff, num_in;

   logic                    is_alpha, is_digit, is_space, is_punct;
   bst_kind_type            punct_kind;
   logic [3:0]              digit_val;
   logic [VALUE_BITS+3:0]   num_prod;
   logic [VALUE_BITS-1:0]   num_sat;
   logic [OFFSET_BITS-1:0]  cur_off_inc;
   logic [LEN_BITS-1:0]     len_grow;

   // outcome of a byte seen between tokens
   logic                    idle_emit, idle_mark;
   mode_type                idle_mode;
   logic [OFFSET_BITS-1:0]  idle_off;
   logic [LEN_BITS-1:0]     idle_len;
   logic [VALUE_BITS-1:0]   idle_num;
   bst_result_type          idle_res, pend_res, r0, r1;
   bst_kind_type            idle_kind, pend_kind;
   logic [1:0]              cnt;

   assign is_alpha = (char_byte >= CHAR_LOWER_A && char_byte <= CHAR_LOWER_Z) ||
                     (char_byte >= CHAR_UPPER_A && char_byte <= CHAR_UPPER_Z);
   assign is_digit = char_byte >= CHAR_ZERO && char_byte <= CHAR_NINE;
   assign is_space = char_byte == CHAR_SPACE ||
                     (char_byte >= CHAR_TAB && char_byte <= CHAR_CR);
   assign digit_val = char_byte[3:0];

   always_comb begin
      is_punct   = 1'b1;
      punct_kind = KIND_ERROR;
      unique case (char_byte)
         CHAR_LPAREN: punct_kind = KIND_LPAREN;
         CHAR_RPAREN: punct_kind = KIND_RPAREN;
         CHAR_LBRACE: punct_kind = KIND_LBRACE;
         CHAR_RBRACE: punct_kind = KIND_RBRACE;
         CHAR_SEMI:   punct_kind = KIND_SEMI;
         default:     is_punct   = 1'b0;
      endcase
   end

   // value * 10 + digit, saturating
   assign num_prod = (VALUE_BITS+4)'({num_ff, 3'b000}) +
                     (VALUE_BITS+4)'({num_ff, 1'b0}) +
                     (VALUE_BITS+4)'(digit_val);
   assign num_sat  = (num_prod > (VALUE_BITS+4)'(NUM_MAX)) ? NUM_MAX
                                                           : num_prod[VALUE_BITS-1:0];
   assign cur_off_inc = cur_off_ff + OFFSET_BITS'(1);
   assign len_grow    = (tok_len_ff < POS_MAX) ? tok_len_ff + LEN_BITS'(1) : tok_len_ff;

   always_comb begin
      unique case (mode_ff)
         MODE_IDENT:  pend_kind = KIND_IDENT;
         MODE_NUMBER: pend_kind = KIND_NUMBER;
         default:     pend_kind = KIND_STRING;
      endcase
      pend_res = '{kind: pend_kind, row: tok_row_ff, col: tok_col_ff,
                   offset: OFF_BITS'(tok_off_ff), length: tok_len_ff,
                   value: (mode_ff == MODE_NUMBER) ? num_ff : '0, last: 1'b0};
   end

   always_comb begin
      idle_emit = 1'b0;
      idle_mark = 1'b0;
      idle_mode = MODE_IDLE;
      idle_off  = cur_off_ff;
      idle_len  = LEN_BITS'(1);
      idle_num  = '0;
      idle_kind = is_punct ? punct_kind : KIND_ERROR;
      priority if (is_space) begin
      end else if (char_byte == CHAR_HASH) begin
         idle_mode = MODE_COMMENT;
      end else if (is_alpha) begin
         idle_mark = 1'b1;
         idle_mode = MODE_IDENT;
      end else if (is_digit) begin
         idle_mark = 1'b1;
         idle_mode = MODE_NUMBER;
         idle_num  = VALUE_BITS'(digit_val);
      end else if (char_byte == CHAR_QUOTE) begin
         idle_mark = 1'b1;
         idle_mode = MODE_STRING;
         idle_off  = cur_off_inc;
         idle_len  = '0;
      end else begin
         idle_emit = 1'b1;
      end
      idle_res = '{kind: idle_kind, row: cur_row_ff, col: cur_col_ff,
                   offset: OFF_BITS'(cur_off_ff), length: LEN_BITS'(1),
                   value: '0, last: 1'b0};
   end

   always_comb begin
      logic use_idle;
      use_idle   = 1'b0;
      mode_in    = mode_ff;
      tok_row_in = tok_row_ff;
      tok_col_in = tok_col_ff;
      tok_off_in = tok_off_ff;
      tok_len_in = tok_len_ff;
      num_in     = num_ff;
      cnt        = 2'd0;
      r0         = pend_res;
      r1         = idle_res;

      if (char_byte == CHAR_NEWLINE) begin
         cur_row_in = (cur_row_ff < POS_MAX) ? cur_row_ff + ROW_BITS'(1) : cur_row_ff;
         cur_col_in = '0;
      end else begin
         cur_row_in = cur_row_ff;
         cur_col_in = (cur_col_ff < POS_MAX) ? cur_col_ff + ROW_BITS'(1) : cur_col_ff;
      end
      cur_off_in = cur_off_inc;

      if (end_marker) begin
         if (mode_ff == MODE_IDENT || mode_ff == MODE_NUMBER || mode_ff == MODE_STRING) begin
            cnt = 2'd1;
         end
         mode_in    = MODE_IDLE;
         cur_row_in = '0;
         cur_col_in = '0;
         cur_off_in = '0;
         tok_row_in = '0;
         tok_col_in = '0;
         tok_off_in = '0;
         tok_len_in = '0;
         num_in     = '0;
      end else begin
         unique case (mode_ff)
            MODE_IDENT: begin
               if (is_alpha || is_digit) begin
                  tok_len_in = len_grow;
               end else begin
                  use_idle = 1'b1;
                  cnt      = idle_emit ? 2'd2 : 2'd1;
               end
            end
            MODE_NUMBER: begin
               if (is_digit) begin
                  num_in     = num_sat;
                  tok_len_in = len_grow;
               end else begin
                  use_idle = 1'b1;
                  cnt      = idle_emit ? 2'd2 : 2'd1;
               end
            end
            MODE_STRING: begin
               if (char_byte == CHAR_QUOTE) begin
                  mode_in = MODE_IDLE;
                  cnt     = 2'd1;
               end else begin
                  tok_len_in = len_grow;
               end
            end
            MODE_COMMENT: begin
               if (char_byte == CHAR_NEWLINE) begin
                  mode_in = MODE_IDLE;
               end
            end
            default: begin
               use_idle = 1'b1;
               r0       = idle_res;
               cnt      = idle_emit ? 2'd1 : 2'd0;
            end
         endcase
         if (use_idle) begin
            mode_in = idle_mode;
            if (idle_mark) begin
               tok_row_in = cur_row_ff;
               tok_col_in = cur_col_ff;
               tok_off_in = idle_off;
               tok_len_in = idle_len;
               num_in     = idle_num;
            end
         end
      end

      r0.last    = (cnt == 2'd1);
      r1.last    = (cnt == 2'd2);
      push.count = cnt;
      push.r0    = r0;
      push.r1    = r1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff    <= MODE_IDLE;
         cur_row_ff <= '0;
         cur_col_ff <= '0;
         cur_off_ff <= '0;
         tok_row_ff <= '0;
         tok_col_ff <= '0;
         tok_off_ff <= '0;
         tok_len_ff <= '0;
         num_ff     <= '0;
      end else if (take) begin
         mode_ff    <= mode_in;
         cur_row_ff <= cur_row_in;
         cur_col_ff <= cur_col_in;
         cur_off_ff <= cur_off_in;
         tok_row_ff <= tok_row_in;
         tok_col_ff <= tok_col_in;
         tok_off_ff <= tok_off_in;
         tok_len_ff <= tok_len_in;
         num_ff     <= num_in;
      end
   end

endmodule
`default_nettype wire

>>> src/bst_outq.sv
// Result queue: three registered result slots, up to two pushed and one popped a cycle while rsp_stall is low.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module bst_outq (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   take,
   input  bst_pkg::bst_push_type       push,
   input  wire logic                   rsp_stall,
   output logic                        req_stall,
   output logic                        rsp_valid,
   output bst_pkg::bst_result_type     head
);
   import bst_pkg::*;

   localparam int DEPTH = 3;

   bst_result_type q_ff [DEPTH];
   bst_result_type q_in [DEPTH];
   bst_result_type shifted [DEPTH];
   logic [1:0]     count_ff, count_in;
   logic [1:0]     base, push_num;
   logic           pop;

   assign rsp_valid = count_ff != 2'd0;
   assign head      = q_ff[0];
   assign pop       = rsp_valid && !rsp_stall;
   // room for two results once this cycle's pop is counted
   assign req_stall = !(count_ff < 2'd2 || (count_ff == 2'd2 && pop));
   assign push_num  = take ? push.count : 2'd0;
   assign base      = count_ff - {1'b0, pop};
   assign count_in  = base + push_num;

   always_comb begin
      shifted[0] = pop ? q_ff[1] : q_ff[0];
      shifted[1] = pop ? q_ff[2] : q_ff[1];
      shifted[2] = q_ff[2];
      for (int i = 0; i < DEPTH; i++) begin
         q_in[i] = shifted[i];
         if (push_num != 2'd0 && base == 2'(i)) begin
            q_in[i] = push.r0;
         end
         if (push_num == 2'd2 && base + 2'd1 == 2'(i)) begin
            q_in[i] = push.r1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
      for (int i = 0; i < DEPTH; i++) begin
         q_ff[i] <= q_in[i];
      end
   end

   `ASSERT_IMPLIES(a_room_for_two, clock, reset, take && count_ff == 2'd2, pop)
   `ASSERT_IMPLIES(a_push_count, clock, reset, take, push.count != 2'd3)
   `ASSERT_NEXT(a_drain, clock, reset, pop && push_num == 2'd0, count_ff == $past(count_ff) - 2'd1)

endmodule
`default_nettype wire
